[sv/plb_pkg.sv]
package plb_pkg;

    // request codes
    localparam logic [2:0] REQ_INSERT    = 3'd0;
    localparam logic [2:0] REQ_APPEND    = 3'd1;
    localparam logic [2:0] REQ_ERASE     = 3'd2;
    localparam logic [2:0] REQ_READ      = 3'd3;
    localparam logic [2:0] REQ_OVERWRITE = 3'd4;
    localparam logic [2:0] REQ_FIND      = 3'd5;
    localparam logic [2:0] REQ_CLEAR     = 3'd6;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_POS   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // matches scanned per cycle by the finder
    localparam int unsigned SCAN_LANES = 8;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [6:0]         position;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data_out;
        logic [5:0]         found_index;
        logic [6:0]         entry_count;
        logic               is_full;
        logic               is_empty;
    } t_out_item;

    // command broadcast to every cell
    typedef struct packed {
        logic en;
        logic ins;
        logic ers;
        logic wr;
        logic tap;
        logic cmp;
    } t_cell_ctl;

    // finder status back to the controller
    typedef struct packed {
        logic done;
        logic hit;
    } t_scan_st;

endpackage

[sv/plb_cell.sv]
module plb_cell #(
    parameter int unsigned IDX        = 0,
    parameter int unsigned WORD_WIDTH = 32,
    parameter int unsigned PW         = 6,
    parameter int unsigned CW         = 7
) (
    input  logic                  i_clk,
    input  plb_pkg::t_cell_ctl    i_ctl,
    input  logic [PW-1:0]         i_pos,
    input  logic [CW-1:0]         i_count,
    input  logic [WORD_WIDTH-1:0] i_value,
    input  logic [WORD_WIDTH-1:0] i_left,
    input  logic [WORD_WIDTH-1:0] i_right,
    output logic [WORD_WIDTH-1:0] o_word,
    output logic [WORD_WIDTH-1:0] o_tap,
    output logic                  o_match
);
    import plb_pkg::*;

    logic [WORD_WIDTH-1:0] r_word;
    logic [WORD_WIDTH-1:0] r_tap;
    logic                  r_match;
    logic                  w_at_pos;
    logic                  w_above_pos;
    logic                  w_in_list;

    assign w_at_pos    = (i_pos == PW'(IDX));
    assign w_above_pos = (PW'(IDX) > i_pos);
    assign w_in_list   = (CW'(IDX) < i_count);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            // sample before the word moves so erase returns the old entry
            r_tap   <= (i_ctl.tap && w_at_pos) ? r_word : '0;
            r_match <= i_ctl.cmp && w_in_list && (r_word == i_value);
            if (i_ctl.ins) begin
                if (w_at_pos) begin
                    r_word <= i_value;
                end else if (w_above_pos) begin
                    r_word <= i_left;
                end
            end else if (i_ctl.ers) begin
                if (w_at_pos || w_above_pos) begin
                    r_word <= i_right;
                end
            end else if (i_ctl.wr && w_at_pos) begin
                r_word <= i_value;
            end
        end
    end

    assign o_word  = r_word;
    assign o_tap   = r_tap;
    assign o_match = r_match;

endmodule

[sv/plb_find.sv]
module plb_find #(
    parameter int unsigned CAPACITY = 64,
    parameter int unsigned PW       = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [CAPACITY-1:0] i_match,
    output plb_pkg::t_scan_st   o_st,
    output logic [PW-1:0]       o_index
);
    import plb_pkg::*;

    localparam int unsigned NCH  = (CAPACITY + SCAN_LANES - 1) / SCAN_LANES;
    localparam int unsigned CHW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int unsigned PADW = NCH * SCAN_LANES;

    logic [PADW-1:0]       w_padded;
    logic [SCAN_LANES-1:0] w_slice;
    logic [2:0]            w_enc;
    logic [CHW+2:0]        w_full_idx;
    logic                  w_last;
    logic [CHW-1:0]        r_chunk;
    logic                  r_busy;
    logic                  r_done;
    logic                  r_hit;
    logic [PW-1:0]         r_index;

    assign w_padded   = PADW'(i_match);
    assign w_slice    = w_padded[{r_chunk, 3'b000} +: SCAN_LANES];
    assign w_full_idx = {r_chunk, w_enc};
    assign w_last     = (r_chunk == CHW'(NCH - 1));

    // lowest set lane wins
    always_comb begin
        w_enc = '0;
        for (int k = SCAN_LANES - 1; k >= 0; k--) begin
            if (w_slice[k]) begin
                w_enc = 3'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && ((|w_slice) || w_last);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && ((|w_slice) || w_last)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_chunk <= '0;
        end else if (r_busy) begin
            r_hit   <= |w_slice;
            r_index <= (|w_slice) ? w_full_idx[PW-1:0] : '0;
            if (!(|w_slice) && !w_last) begin
                r_chunk <= r_chunk + 1'b1;
            end
        end
    end

    assign o_st.done = r_done;
    assign o_st.hit  = r_hit;
    assign o_index   = r_index;

endmodule

[sv/positional_list_buffer.sv]
// Channel | Direction | Handshake                    | Payload
// input   | in        | i_in_valid / o_in_ready      | i_in_data  (t_in_item)
// output  | out       | o_out_valid / i_out_ready    | o_out_data (t_out_item)
//
// Every request except find passes through an execute state, in which all cells shift,
// write, tap and compare together, and a done state that loads the output register.
// Find adds a scan state after execute, in which the finder scans groups of 8 cells
// until a hit or the last group, at most CAPACITY/8 (rounded up) groups.
// Synchronous active-low reset empties the list; stored words are not cleared.
// A stalled output holds the finished result and blocks the next item.
module positional_list_buffer #(
    parameter int unsigned CAPACITY   = 64,
    parameter int unsigned WORD_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  plb_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output plb_pkg::t_out_item  o_out_data
);
    import plb_pkg::*;

    localparam int unsigned CW   = $clog2(CAPACITY + 1);
    localparam int unsigned PW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CMPW = (CW > 7) ? CW : 7;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    t_in_item              r_req;
    logic [CW-1:0]         r_count, n_count;
    logic [1:0]            r_status, n_status;
    logic [PW-1:0]         r_found;
    t_out_item             r_out;
    logic                  r_out_valid;

    t_cell_ctl             w_ctl;
    logic [PW-1:0]         w_pos;
    logic [WORD_WIDTH-1:0] w_value;
    logic [WORD_WIDTH+31:0] w_value_ext;
    logic [CMPW-1:0]       w_pos_c;
    logic [CMPW-1:0]       w_cnt_c;
    logic                  w_full;
    logic                  w_load;
    logic                  w_accept;
    logic                  w_start;
    t_scan_st              w_scan;
    logic [PW-1:0]         w_scan_idx;
    logic [CAPACITY-1:0]   w_match;
    logic [WORD_WIDTH-1:0] w_word [CAPACITY];
    logic [WORD_WIDTH-1:0] w_tap  [CAPACITY];
    logic [WORD_WIDTH-1:0] w_tap_or;
    logic [WORD_WIDTH+31:0] w_data_ext;
    logic [PW+5:0]         w_found_ext;
    logic [CW+6:0]         w_count_ext;

    assign w_value_ext = {{WORD_WIDTH{1'b0}}, r_req.value};
    assign w_value = w_value_ext[WORD_WIDTH-1:0];

    assign w_pos_c = CMPW'(r_req.position);
    assign w_cnt_c = CMPW'(r_count);
    assign w_full  = (r_count == CW'(CAPACITY));

    // status and new count, decided in the execute cycle
    always_comb begin
        n_status = ST_OK;
        n_count  = r_count;
        case (r_req.req_type)
            REQ_INSERT: begin
                if (w_pos_c > w_cnt_c) begin
                    n_status = ST_BAD_POS;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            REQ_APPEND: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            REQ_ERASE: begin
                if (w_pos_c >= w_cnt_c) begin
                    n_status = ST_BAD_POS;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            REQ_READ, REQ_OVERWRITE: begin
                if (w_pos_c >= w_cnt_c) begin
                    n_status = ST_BAD_POS;
                end
            end
            REQ_CLEAR: n_count = '0;
            default: n_status = ST_OK;
        endcase
    end

    always_comb begin
        w_ctl.en  = (r_state == S_EXEC);
        w_ctl.ins = ((r_req.req_type == REQ_INSERT) || (r_req.req_type == REQ_APPEND))
                    && (n_status == ST_OK);
        w_ctl.ers = (r_req.req_type == REQ_ERASE) && (n_status == ST_OK);
        w_ctl.wr  = (r_req.req_type == REQ_OVERWRITE) && (n_status == ST_OK);
        w_ctl.tap = (r_req.req_type == REQ_READ) || (r_req.req_type == REQ_ERASE);
        w_ctl.cmp = (r_req.req_type == REQ_FIND);
    end

    assign w_pos = (r_req.req_type == REQ_APPEND) ? PW'(r_count) : PW'(r_req.position);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [WORD_WIDTH-1:0] w_left;
        logic [WORD_WIDTH-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_word[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_word[g];
        end else begin : g_mid_r
            assign w_right = w_word[g+1];
        end
        plb_cell #(
            .IDX        (g),
            .WORD_WIDTH (WORD_WIDTH),
            .PW         (PW),
            .CW         (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_pos   (w_pos),
            .i_count (r_count),
            .i_value (w_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_word  (w_word[g]),
            .o_tap   (w_tap[g]),
            .o_match (w_match[g])
        );
    end

    assign w_start = (r_state == S_EXEC) && (r_req.req_type == REQ_FIND);

    plb_find #(
        .CAPACITY (CAPACITY),
        .PW       (PW)
    ) u_find (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_match (w_match),
        .o_st    (w_scan),
        .o_index (w_scan_idx)
    );

    // only the addressed cell taps a nonzero word
    always_comb begin
        w_tap_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_tap_or = w_tap_or | w_tap[k];
        end
    end

    assign w_data_ext  = {{32{w_tap_or[WORD_WIDTH-1]}}, w_tap_or};
    assign w_found_ext = {6'b0, r_found};
    assign w_count_ext = {7'b0, r_count};

    assign w_load     = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == S_IDLE) || w_load;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_EXEC;
            S_EXEC: n_state = (r_req.req_type == REQ_FIND) ? S_SCAN : S_DONE;
            S_SCAN: if (w_scan.done) n_state = S_DONE;
            S_DONE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end else if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) begin
                r_count <= n_count;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in_data;
        end
        if (r_state == S_EXEC) begin
            r_status <= n_status;
            r_found  <= '0;
        end else if ((r_state == S_SCAN) && w_scan.done) begin
            r_status <= w_scan.hit ? ST_OK : ST_NOT_FOUND;
            r_found  <= w_scan.hit ? w_scan_idx : '0;
        end
        if (w_load) begin
            r_out.status      <= r_status;
            r_out.data_out    <= (w_ctl.tap && (r_status == ST_OK)) ? w_data_ext[31:0] : '0;
            r_out.found_index <= w_found_ext[5:0];
            r_out.entry_count <= w_count_ext[6:0];
            r_out.is_full     <= w_full;
            r_out.is_empty    <= (r_count == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[sim/positional_list_buffer_checker.sv]
`timescale 1ns / 100ps

module positional_list_buffer_checker #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  plb_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  plb_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import plb_pkg::*;

    logic [31:0] list_words [CAPACITY];
    int unsigned word_count = 0;
    int          fail_count = 0;
    int          pending    = 0;
    t_out_item   expected_results [$];

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    // Apply one request to the list image and return the result it produces.
    function automatic t_out_item apply_request(t_in_item item);
        t_out_item   res;
        int unsigned pos;
        int unsigned i;
        bit          hit;
        res = '0;
        pos = item.position;
        hit = 1'b0;
        case (item.req_type)
            REQ_INSERT, REQ_APPEND: begin
                if (item.req_type == REQ_APPEND)
                    pos = word_count;
                if (pos > word_count) begin
                    res.status = ST_BAD_POS;
                end else if (word_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = word_count; i > pos; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[pos] = item.value;
                    word_count++;
                end
            end
            REQ_ERASE: begin
                if (pos >= word_count) begin
                    res.status = ST_BAD_POS;
                end else begin
                    res.data_out = list_words[pos];
                    for (i = pos; i + 1 < word_count; i++)
                        list_words[i] = list_words[i + 1];
                    word_count--;
                end
            end
            REQ_READ: begin
                if (pos >= word_count)
                    res.status = ST_BAD_POS;
                else
                    res.data_out = list_words[pos];
            end
            REQ_OVERWRITE: begin
                if (pos >= word_count)
                    res.status = ST_BAD_POS;
                else
                    list_words[pos] = item.value;
            end
            REQ_FIND: begin
                res.status = ST_NOT_FOUND;
                for (i = 0; i < word_count; i++) begin
                    if (!hit && list_words[i] == item.value) begin
                        hit             = 1'b1;
                        res.status      = ST_OK;
                        res.found_index = i[5:0];
                    end
                end
            end
            REQ_CLEAR: begin
                word_count = 0;
            end
            default: begin
                // unused code: no change, zero result
            end
        endcase
        res.entry_count = word_count[6:0];
        res.is_full     = (word_count == CAPACITY);
        res.is_empty    = (word_count == 0);
        return res;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            word_count = 0;
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                expected_results = {expected_results, apply_request(i_in_data)};
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result item with no request waiting");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, i_out_data.status);
                    check_field("data_out", want.data_out, i_out_data.data_out);
                    check_field("found_index", want.found_index, i_out_data.found_index);
                    check_field("entry_count", want.entry_count, i_out_data.entry_count);
                    check_field("is_full", want.is_full, i_out_data.is_full);
                    check_field("is_empty", want.is_empty, i_out_data.is_empty);
                end
            end
        end
        pending <= expected_results.size();
    end

endmodule

[sim/positional_list_buffer_test.sv]
`timescale 1ns / 100ps

module positional_list_buffer_test;
    import plb_pkg::*;

    localparam int unsigned CAPACITY   = 64;
    localparam logic [2:0]  REQ_UNUSED = 3'd7;
    localparam int          STALL_LIMIT = 2000;
    localparam int          RANDOM_PER_PHASE = 380;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    int fail_count;
    int pending;
    int send_gap_pct   = 13;
    int recv_stall_pct = 50;
    int idle_cycles    = 0;
    int unsigned list_len = 0;

    always #4 clk = ~clk;

    positional_list_buffer #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (32)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    positional_list_buffer_checker #(
        .CAPACITY (CAPACITY)
    ) checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // End the run if nothing moves on either channel for too long.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic t_in_item make_item(logic [2:0] req, int unsigned pos,
                                           logic [31:0] word);
        t_in_item item;
        item.req_type = req;
        item.position = pos[6:0];
        item.value    = word;
        return item;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3, 4, 5: return 32'($urandom_range(7));
            default: return $urandom();
        endcase
    endfunction

    // Mostly in-range positions; allow_end permits position == length (insert).
    function automatic int unsigned pick_position(bit allow_end);
        if ($urandom_range(99) < 15)
            return $urandom_range(127);
        if (allow_end)
            return $urandom_range(list_len);
        return (list_len == 0) ? 0 : $urandom_range(list_len - 1);
    endfunction

    task automatic send_item(input t_in_item item);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // track the length to steer positions and the fill and empty loops
        case (item.req_type)
            REQ_INSERT: if (item.position <= list_len && list_len < CAPACITY) list_len++;
            REQ_APPEND: if (list_len < CAPACITY) list_len++;
            REQ_ERASE:  if (item.position < list_len) list_len--;
            REQ_CLEAR:  list_len = 0;
            default: ;
        endcase
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic send_random(input bit grow);
        int       roll;
        int       ins_end;
        int       app_end;
        t_in_item item;
        roll    = $urandom_range(99);
        ins_end = grow ? 25 : 10;
        app_end = grow ? 45 : 18;
        if (roll < ins_end)
            item = make_item(REQ_INSERT, pick_position(1'b1), pick_value());
        else if (roll < app_end)
            item = make_item(REQ_APPEND, $urandom_range(127), pick_value());
        else if (roll < 55)
            item = make_item(REQ_ERASE, pick_position(1'b0), pick_value());
        else if (roll < 70)
            item = make_item(REQ_READ, pick_position(1'b0), pick_value());
        else if (roll < 80)
            item = make_item(REQ_OVERWRITE, pick_position(1'b0), pick_value());
        else if (roll < 96)
            item = make_item(REQ_FIND, $urandom_range(127), pick_value());
        else if (roll < 98)
            item = make_item(REQ_CLEAR, $urandom_range(127), pick_value());
        else
            item = make_item(REQ_UNUSED, $urandom_range(127), pick_value());
        send_item(item);
    endtask

    task automatic run_phase(input int gap_pct, input int stall_pct);
        int n;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n % 400 == 100) begin
                // fill to capacity, push against the full list, then empty it
                while (list_len < CAPACITY)
                    send_item(make_item(REQ_APPEND, $urandom_range(127), pick_value()));
                send_item(make_item(REQ_APPEND, 0, pick_value()));
                send_item(make_item(REQ_INSERT, $urandom_range(CAPACITY), pick_value()));
                send_item(make_item(REQ_INSERT, $urandom_range(127, CAPACITY + 1), 0));
                send_item(make_item(REQ_FIND, 0, pick_value()));
                while (list_len > 0)
                    send_item(make_item(REQ_ERASE, $urandom_range(list_len - 1), 0));
                send_item(make_item(REQ_ERASE, 0, 0));
            end
            send_random((n / 50) % 2 == 0);
        end
        drain_results();
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list first: read, erase, overwrite and insert at 1 are out of range
        send_item(make_item(REQ_READ, 0, 0));
        send_item(make_item(REQ_ERASE, 0, 0));
        send_item(make_item(REQ_OVERWRITE, 0, 32'h1));
        send_item(make_item(REQ_FIND, 0, 0));
        send_item(make_item(REQ_INSERT, 1, 32'h1));
        send_item(make_item(REQ_INSERT, 0, 32'h8000_0000));
        send_item(make_item(REQ_APPEND, 127, 32'h7fff_ffff));
        send_item(make_item(REQ_INSERT, 1, 32'h0));
        send_item(make_item(REQ_APPEND, 0, 32'hffff_ffff));
        send_item(make_item(REQ_INSERT, 4, 32'ha5a5_a5a5));
        send_item(make_item(REQ_INSERT, 127, 32'h1));
        send_item(make_item(REQ_READ, 0, 0));
        send_item(make_item(REQ_READ, 4, 0));
        send_item(make_item(REQ_READ, 5, 0));
        send_item(make_item(REQ_READ, 127, 0));
        send_item(make_item(REQ_OVERWRITE, 2, 32'h5a5a_5a5a));
        send_item(make_item(REQ_FIND, 127, 32'h5a5a_5a5a));
        send_item(make_item(REQ_FIND, 0, 32'hffff_ffff));
        send_item(make_item(REQ_FIND, 0, 32'h1234_5678));
        send_item(make_item(REQ_ERASE, 0, 0));
        send_item(make_item(REQ_ERASE, 3, 0));
        send_item(make_item(REQ_ERASE, 4, 0));
        send_item(make_item(REQ_UNUSED, 127, 32'hffff_ffff));
        send_item(make_item(REQ_CLEAR, 0, 0));
        send_item(make_item(REQ_READ, 0, 0));
        // hold the sender until every result is back
        drain_results();

        run_phase(13, 50);
        run_phase(50, 13);
        run_phase(0, 0);

        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[positional_list_buffer.f]
sv/plb_pkg.sv
sv/plb_cell.sv
sv/plb_find.sv
sv/positional_list_buffer.sv
sim/positional_list_buffer_checker.sv
sim/positional_list_buffer_test.sv
